>>> design/bbc_pkg.sv
// Shared types, constants and helper functions of the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LINE_BITS   = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_STRAY    = 3'd1;
    localparam logic [2:0] ST_WRONG    = 3'd2;
    localparam logic [2:0] ST_STRAYEND = 3'd3;
    localparam logic [2:0] ST_COMMENT  = 3'd4;
    localparam logic [2:0] ST_DQUOTE   = 3'd5;
    localparam logic [2:0] ST_SQUOTE   = 3'd6;
    localparam logic [2:0] ST_UNCLOSED = 3'd7;

    localparam logic [1:0] KIND_PAREN = 2'd0;
    localparam logic [1:0] KIND_BRACE = 2'd1;
    localparam logic [1:0] KIND_BRACK = 2'd2;

    typedef logic [1:0]           kind_t;
    typedef logic [LINE_BITS-1:0] line_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef struct packed {
        kind_t kind;
        line_t line;
    } entry_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        kind_t kind;
        line_t line;
    } stack_cmd_t;

    typedef struct packed {
        cnt_t   count;
        entry_t top;
        entry_t second;
    } stack_stat_t;

    typedef struct packed {
        logic [2:0] status;
        line_t      line;
        logic [7:0] symbol;
        logic       overflow;
    } verdict_t;

    function automatic kind_t kind_of(input logic [7:0] c);
        kind_t k;
        k = KIND_PAREN;
        if (c == CH_LBRACE || c == CH_RBRACE)
        begin
            k = KIND_BRACE;
        end
        else if (c == CH_LBRACK || c == CH_RBRACK)
        begin
            k = KIND_BRACK;
        end
        return k;
    endfunction

    function automatic logic [7:0] opener_char(input kind_t k);
        logic [7:0] c;
        unique case (k)
            KIND_BRACE: c = CH_LBRACE;
            KIND_BRACK: c = CH_LBRACK;
            default:    c = CH_LPAREN;
        endcase
        return c;
    endfunction

endpackage

>>> design/bbc_in_if.sv
// Input channel interface: one source byte and its last-byte mark per transaction.
interface bbc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink (input valid, input ch, input last, output ready);
endinterface

>>> design/bbc_out_if.sv
// Output channel interface: one verdict per transaction.
interface bbc_out_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [bbc_pkg::LINE_BITS-1:0] line;
    logic [7:0]                   symbol;
    logic                         overflow;

    modport source (output valid, output status, output line, output symbol,
                    output overflow, input ready);
    modport sink (input valid, input status, input line, input symbol,
                  input overflow, output ready);
endinterface

>>> design/bbc_stack.sv
// Bracket stack: top entry in registers, deeper entries in a synchronous memory.
module bbc_stack (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbc_pkg::stack_cmd_t  cmd,
    output bbc_pkg::stack_stat_t stat
);
    import bbc_pkg::*;

    entry_t          mem [STACK_DEPTH];
    cnt_t            count_reg;
    cnt_t            count_next;
    entry_t          top_reg;
    entry_t          rd_data_reg;
    entry_t          fwd_data_reg;
    logic            fwd_reg;
    logic            wr_en;
    cnt_t            wr_cnt;
    cnt_t            rd_cnt;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t          second;

    assign second = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign wr_en  = cmd.push && (count_reg != '0);
    assign wr_cnt = count_reg - CNT_W'(1);
    assign wr_addr = wr_cnt[ADDR_W-1:0];

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign rd_cnt  = count_next - CNT_W'(2);
    assign rd_addr = rd_cnt[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        rd_data_reg  <= mem[rd_addr];
        fwd_data_reg <= top_reg;
        if (cmd.push)
        begin
            top_reg <= '{kind: cmd.kind, line: cmd.line};
        end
        else if (cmd.pop)
        begin
            top_reg <= second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fwd_reg   <= wr_en;
        end
    end

    assign stat.count  = count_reg;
    assign stat.top    = top_reg;
    assign stat.second = second;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("Stack count exceeds the stack depth.");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> count_reg < CNT_W'(STACK_DEPTH))
        else $error("Push issued onto a full stack.");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> count_reg == '0)
        else $error("Stack not empty after a clear.");

endmodule

>>> design/bbc_scan.sv
// Scanner: comment and quote tracking, line counter, error latch and verdict.
module bbc_scan (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 acc,
    input  logic [7:0]           ch,
    input  logic                 last,
    input  bbc_pkg::stack_stat_t stat,
    output bbc_pkg::stack_cmd_t  cmd,
    output logic                 res_valid,
    output bbc_pkg::verdict_t    res
);
    import bbc_pkg::*;

    localparam logic [3:0] M_NORMAL    = 4'd0;
    localparam logic [3:0] M_SLASH     = 4'd1;
    localparam logic [3:0] M_STAR      = 4'd2;
    localparam logic [3:0] M_LINECOM   = 4'd3;
    localparam logic [3:0] M_BLOCK     = 4'd4;
    localparam logic [3:0] M_BLOCKSTAR = 4'd5;
    localparam logic [3:0] M_DQUOTE    = 4'd6;
    localparam logic [3:0] M_SQUOTE    = 4'd7;
    localparam logic [3:0] M_HALT      = 4'd8;

    logic [3:0] mode_reg, mode_next;
    line_t      line_reg, line_next;
    line_t      col_reg, col_next;
    logic [2:0] err_reg, err_next;
    line_t      eline_reg, eline_next;
    logic [7:0] esym_reg, esym_next;
    line_t      line_inc;
    logic       plain;
    cnt_t       cnt_after;
    entry_t     top_after;

    assign line_inc = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        err_next   = err_reg;
        eline_next = eline_reg;
        esym_next  = esym_reg;
        plain      = 1'b0;
        cmd.push   = 1'b0;
        cmd.pop    = 1'b0;
        cmd.clear  = acc && last;
        cmd.kind   = kind_of(ch);
        cmd.line   = line_reg;
        if (acc)
        begin
            unique case (mode_reg)
                M_NORMAL:
                begin
                    plain = 1'b1;
                end
                M_SLASH:
                begin
                    if (ch == CH_SLASH)
                    begin
                        mode_next = M_LINECOM;
                    end
                    else if (ch == CH_STAR)
                    begin
                        col_next  = line_reg;
                        mode_next = M_BLOCK;
                    end
                    else
                    begin
                        mode_next = M_NORMAL;
                        plain     = 1'b1;
                    end
                end
                M_STAR:
                begin
                    if (ch == CH_SLASH)
                    begin
                        err_next   = ST_STRAYEND;
                        eline_next = line_reg;
                        esym_next  = CH_STAR;
                        mode_next  = M_HALT;
                    end
                    else
                    begin
                        mode_next = M_NORMAL;
                        plain     = 1'b1;
                    end
                end
                M_LINECOM:
                begin
                    if (ch == CH_NL)
                    begin
                        line_next = line_inc;
                        mode_next = M_NORMAL;
                    end
                end
                M_BLOCK, M_BLOCKSTAR:
                begin
                    if (mode_reg == M_BLOCKSTAR && ch == CH_SLASH)
                    begin
                        mode_next = M_NORMAL;
                    end
                    else
                    begin
                        if (ch == CH_NL)
                        begin
                            line_next = line_inc;
                        end
                        mode_next = (ch == CH_STAR) ? M_BLOCKSTAR : M_BLOCK;
                    end
                end
                M_DQUOTE:
                begin
                    if (ch == CH_NL)
                    begin
                        line_next = line_inc;
                    end
                    else if (ch == CH_DQUOTE)
                    begin
                        mode_next = M_NORMAL;
                    end
                end
                M_SQUOTE:
                begin
                    if (ch == CH_NL)
                    begin
                        line_next = line_inc;
                    end
                    else if (ch == CH_SQUOTE)
                    begin
                        mode_next = M_NORMAL;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (plain)
        begin
            unique case (ch)
                CH_SLASH:  mode_next = M_SLASH;
                CH_STAR:   mode_next = M_STAR;
                CH_DQUOTE: mode_next = M_DQUOTE;
                CH_SQUOTE: mode_next = M_SQUOTE;
                CH_NL:     line_next = line_inc;
                CH_LPAREN, CH_LBRACE, CH_LBRACK:
                begin
                    if (stat.count >= CNT_W'(STACK_DEPTH))
                    begin
                        err_next   = ST_UNCLOSED;
                        eline_next = line_reg;
                        esym_next  = ch;
                        mode_next  = M_HALT;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
                CH_RPAREN, CH_RBRACE, CH_RBRACK:
                begin
                    if (stat.count == '0)
                    begin
                        err_next   = ST_STRAY;
                        eline_next = line_reg;
                        esym_next  = ch;
                        mode_next  = M_HALT;
                    end
                    else
                    begin
                        cmd.pop = 1'b1;
                        if (stat.top.kind != kind_of(ch))
                        begin
                            err_next   = ST_WRONG;
                            eline_next = line_reg;
                            esym_next  = ch;
                            mode_next  = M_HALT;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cnt_after = stat.count;
        top_after = stat.top;
        if (cmd.push)
        begin
            cnt_after = stat.count + CNT_W'(1);
            top_after = '{kind: cmd.kind, line: cmd.line};
        end
        else if (cmd.pop)
        begin
            cnt_after = stat.count - CNT_W'(1);
            top_after = stat.second;
        end
    end

    always_comb
    begin
        res = '{status: ST_OK, line: '0, symbol: 8'h00, overflow: 1'b0};
        priority if (err_next != ST_OK)
        begin
            res.status   = err_next;
            res.line     = eline_next;
            res.symbol   = esym_next;
            res.overflow = (err_next == ST_UNCLOSED);
        end
        else if (mode_next == M_BLOCK || mode_next == M_BLOCKSTAR)
        begin
            res.status = ST_COMMENT;
            res.line   = col_next;
            res.symbol = CH_SLASH;
        end
        else if (mode_next == M_DQUOTE)
        begin
            res.status = ST_DQUOTE;
            res.line   = line_next;
            res.symbol = CH_DQUOTE;
        end
        else if (mode_next == M_SQUOTE)
        begin
            res.status = ST_SQUOTE;
            res.line   = line_next;
            res.symbol = CH_SQUOTE;
        end
        else if (cnt_after != '0)
        begin
            res.status = ST_UNCLOSED;
            res.line   = top_after.line;
            res.symbol = opener_char(top_after.kind);
        end
    end

    assign res_valid = acc && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_NORMAL;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= LINE_BITS'(1);
            err_reg   <= ST_OK;
            eline_reg <= '0;
            esym_reg  <= 8'h00;
        end
        else if (acc && last)
        begin
            mode_reg  <= M_NORMAL;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= LINE_BITS'(1);
            err_reg   <= ST_OK;
            eline_reg <= '0;
            esym_reg  <= 8'h00;
        end
        else
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            err_reg   <= err_next;
            eline_reg <= eline_next;
            esym_reg  <= esym_next;
        end
    end

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK |-> mode_reg == M_HALT)
        else $error("Latched error without the halt mode.");

    a_halt_has_err: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_HALT |-> err_reg != ST_OK)
        else $error("Halt mode entered without a latched error.");

endmodule

>>> design/source_bracket_balance_checker.sv
// Top level of the bracket balance checker: scanner, stack and output register.
//
// The input channel carries one byte of source text per transaction, with a
// flag that marks the final byte of a text. A new transaction is accepted
// in every cycle while the output register is empty or being drained. The
// stack keeps its top entry in registers and the deeper entries in a
// synchronous memory with a registered read; the entry below the top is
// prefetched each cycle, and a push forwards the displaced top, so
// consecutive pushes and pops run at full rate.
// Bytes without the final mark produce nothing. The final byte produces one
// verdict transaction on the output channel in the cycle after it is
// accepted, and the block then starts afresh on the next text.
// Reset empties the stack, sets the line counter to one and clears any
// latched error; the stack memory needs no clearing pass. While the receiver
// stalls with a verdict held, input is refused until the verdict is taken.
module source_bracket_balance_checker (
    input logic clk,
    input logic rst_n,
    bbc_in_if.sink    in_ch,
    bbc_out_if.source out_ch
);
    import bbc_pkg::*;

    stack_cmd_t  cmd;
    stack_stat_t stat;
    verdict_t    res;
    verdict_t    out_reg;
    logic        res_valid;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        acc;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign acc         = in_ch.valid && in_ch.ready;

    bbc_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .ch        (in_ch.ch),
        .last      (in_ch.last),
        .stat      (stat),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res       (res)
    );

    bbc_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.status   = out_reg.status;
    assign out_ch.line     = out_reg.line;
    assign out_ch.symbol   = out_reg.symbol;
    assign out_ch.overflow = out_reg.overflow;

    a_verdict_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && in_ch.last |=> out_valid_reg)
        else $error("Final byte accepted but no verdict transaction follows.");

endmodule
